FILE: sv/lmts_pkg.sv
// Package for the LCD mode timing sequencer: mode type, timing constants,
// configuration and result structs, and the mode-to-code mapping.
// No dependencies; imported by every module of the block.
package lmts_pkg;

  localparam int unsigned DotW  = 10;
  localparam int unsigned LineW = 8;

  localparam logic [DotW-1:0] OamLen    = 10'd80;
  localparam logic [DotW-1:0] VramLen   = 10'd172;
  localparam logic [DotW-1:0] HblankLen = 10'd204;
  localparam logic [DotW-1:0] VblankLen = 10'd456;

  localparam logic [LineW-1:0] VisibleLines = 8'd144;
  localparam logic [LineW-1:0] TotalLines   = 8'd154;

  // Output codes of the mode field.
  localparam logic [1:0] CodeOam    = 2'd0;
  localparam logic [1:0] CodeVram   = 2'd1;
  localparam logic [1:0] CodeHblank = 2'd2;
  localparam logic [1:0] CodeVblank = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegLineCompare = 2'd0;
  localparam logic [1:0] RegIrqEnables  = 2'd1;
  localparam logic [1:0] RegIrqMaster   = 2'd2;

  // Bits of the request enable register.
  localparam int unsigned EnHblank = 0;
  localparam int unsigned EnVblank = 1;
  localparam int unsigned EnOam    = 2;
  localparam int unsigned EnCoinc  = 3;

  typedef enum logic [3:0] {
    ModeOam    = 4'b0001,
    ModeVram   = 4'b0010,
    ModeHblank = 4'b0100,
    ModeVblank = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [LineW-1:0] line_compare;
    logic [3:0]       irq_enables;
    logic             irq_master;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       lcd_mode;
    logic [LineW-1:0] line_number;
    logic             coincidence;
    logic             render_pulse;
    logic             stat_request;
    logic             vblank_request;
  } res_t;

  function automatic logic [1:0] mode_code(mode_e mode);
    logic [1:0] code;
    unique case (mode)
      ModeOam:    code = CodeOam;
      ModeVram:   code = CodeVram;
      ModeHblank: code = CodeHblank;
      ModeVblank: code = CodeVblank;
      default:    code = CodeOam;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/lcd_mode_timing_sequencer_core.sv
// LCD mode timing sequencer, top level: input register, step logic, result
// register and handshakes. Depends on lmts_pkg, lmts_cfg and lmts_step.

// Each input beat is a tick of elapsed machine cycles; every tick yields
// exactly one result beat carrying the mode, line, coincidence flag and the
// render, status and vblank pulses. The block takes one tick per clock cycle
// while no finished result is held waiting. A tick is first held in the
// input register. When the pipeline advances, the compare-and-increment on
// the timing state registers runs and loads the result register, which
// offers the result. While a finished result waits to be taken, the input
// register still takes one more tick; further ticks are held off until the
// result drains.
// Configuration writes are taken in any cycle and should be made while the
// block is idle. There is no clearing pass after reset.
module lcd_mode_timing_sequencer_core import lmts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       cycle_delta_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       lcd_mode_o,
  output logic [LineW-1:0] line_number_o,
  output logic             coincidence_o,
  output logic             render_pulse_o,
  output logic             stat_request_o,
  output logic             vblank_request_o
);

  cfg_t       cfg;
  res_t       res, res_q;
  logic       in_valid_q, out_valid_q;
  logic [7:0] delta_q;
  logic       advance, step_fire;

  assign cfg_ready_o = 1'b1;

  lmts_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The pipeline moves whenever the result register is empty or drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign step_fire  = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      delta_q <= cycle_delta_i;
    end
  end

  lmts_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_fire),
    .delta_i   (delta_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign lcd_mode_o       = res_q.lcd_mode;
  assign line_number_o    = res_q.line_number;
  assign coincidence_o    = res_q.coincidence;
  assign render_pulse_o   = res_q.render_pulse;
  assign stat_request_o   = res_q.stat_request;
  assign vblank_request_o = res_q.vblank_request;

  a_vblank_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vblank_request_o |-> lcd_mode_o == CodeVblank)
    else $error("vblank request without vblank mode");

  a_render_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && render_pulse_o |-> lcd_mode_o == CodeHblank)
    else $error("render pulse outside hblank entry");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> line_number_o < TotalLines)
    else $error("line number out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while result register can drain");

endmodule

FILE: sv/lmts_cfg.sv
// Configuration register file of the LCD mode timing sequencer.
// Depends on lmts_pkg for the register indexes and the cfg_t struct.
module lmts_cfg import lmts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [1:0] wr_index_i,
  input  logic [7:0] wr_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegLineCompare: cfg_d.line_compare = wr_data_i[LineW-1:0];
        RegIrqEnables:  cfg_d.irq_enables  = wr_data_i[3:0];
        RegIrqMaster:   cfg_d.irq_master   = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/lmts_step.sv
// Timing state of the sequencer (dot counter, mode, line, coincidence) and
// the single-pass next-state logic for one tick. Depends on lmts_pkg.
module lmts_step import lmts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  logic [7:0] delta_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic [DotW-1:0]  dot_q, dot_d, dot_sum;
  mode_e            mode_q, mode_d;
  logic [LineW-1:0] line_q, line_d, line_inc;
  logic             coinc_q, coinc_d;
  logic             render, stat, vblank;

  assign dot_sum  = dot_q + {{(DotW-8){1'b0}}, delta_i};
  assign line_inc = line_q + {{(LineW-1){1'b0}}, 1'b1};

  always_comb begin
    dot_d   = dot_sum;
    mode_d  = mode_q;
    line_d  = line_q;
    coinc_d = coinc_q;
    render  = 1'b0;
    stat    = 1'b0;
    vblank  = 1'b0;
    unique case (mode_q)
      ModeOam: begin
        if (dot_sum >= OamLen) begin
          dot_d  = '0;
          mode_d = ModeVram;
        end
      end
      ModeVram: begin
        if (dot_sum >= VramLen) begin
          dot_d  = '0;
          mode_d = ModeHblank;
          render = 1'b1;
          stat   = cfg_i.irq_master & cfg_i.irq_enables[EnHblank];
        end
      end
      ModeHblank: begin
        if (dot_sum >= HblankLen) begin
          dot_d   = '0;
          line_d  = line_inc;
          coinc_d = (line_inc == cfg_i.line_compare);
          // The coincidence request ignores the master enable.
          stat    = coinc_d & cfg_i.irq_enables[EnCoinc];
          if (line_inc < VisibleLines) begin
            mode_d = ModeOam;
          end else begin
            mode_d = ModeVblank;
            vblank = 1'b1;
            stat   = stat | (cfg_i.irq_master & cfg_i.irq_enables[EnVblank]);
          end
        end
      end
      ModeVblank: begin
        if (dot_sum >= VblankLen) begin
          dot_d  = '0;
          line_d = line_inc;
          if (line_inc >= TotalLines) begin
            line_d = '0;
            mode_d = ModeOam;
            stat   = cfg_i.irq_master & cfg_i.irq_enables[EnOam];
          end
        end
      end
      default: mode_d = ModeOam;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= '0;
      mode_q  <= ModeOam;
      line_q  <= '0;
      coinc_q <= 1'b0;
    end else if (step_en_i) begin
      dot_q   <= dot_d;
      mode_q  <= mode_d;
      line_q  <= line_d;
      coinc_q <= coinc_d;
    end
  end

  assign res_o.lcd_mode       = mode_code(mode_d);
  assign res_o.line_number    = line_d;
  assign res_o.coincidence    = coinc_d;
  assign res_o.render_pulse   = render;
  assign res_o.stat_request   = stat;
  assign res_o.vblank_request = vblank;

endmodule
